// ===== rtl/duv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// duv_pkg
// Shared widths and the bundles that travel down the pipeline of the
// displacement / unit vector block.
// ----------------------------------------------------------------------------
package duv_pkg;

    localparam int COORD_W = 31;              // Q15.16 coordinate
    localparam int DIFF_W  = 32;              // component difference / magnitude
    localparam int SUM_W   = 64;              // sum of squares
    localparam int ROOT_W  = SUM_W / 2;       // distance
    localparam int REM_W   = ROOT_W + 2;      // root remainder
    localparam int DREM_W  = DIFF_W + 1;      // division remainder
    localparam int OUT_W   = 32;              // Q2.30 component
    localparam int UNIT_FRAC_BITS_DEF = 30;

    // carried alongside the square root
    typedef struct packed {
        logic [2:0][DIFF_W-1:0] mag;
        logic [2:0]             neg;
        logic                   zero;
    } side_t;

    // carried alongside the divider
    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [2:0]        neg;
        logic              zero;
    } tag_t;

endpackage
`default_nettype wire

// ===== rtl/duv_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// duv_front
// Difference, magnitude, squares and sum of squares: four register stages.
// ----------------------------------------------------------------------------
module duv_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_vld,
    input  wire logic signed [duv_pkg::COORD_W-1:0]  ax,
    input  wire logic signed [duv_pkg::COORD_W-1:0]  ay,
    input  wire logic signed [duv_pkg::COORD_W-1:0]  az,
    input  wire logic signed [duv_pkg::COORD_W-1:0]  bx,
    input  wire logic signed [duv_pkg::COORD_W-1:0]  by,
    input  wire logic signed [duv_pkg::COORD_W-1:0]  bz,
    output logic                                     vld,
    output duv_pkg::side_t                           side,
    output logic [duv_pkg::SUM_W-1:0]                sum
);
    import duv_pkg::*;

    logic [3:0]                    vld_reg;
    logic signed [DIFF_W-1:0]      d_reg [3];
    logic signed [DIFF_W-1:0]      d_next [3];
    side_t                         side1_reg, side1_next;
    side_t                         side2_reg;
    side_t                         side3_reg;
    logic [SUM_W-1:0]              sq_reg [3];
    logic [SUM_W-1:0]              sq_next [3];
    logic [SUM_W-1:0]              sum_reg, sum_next;

    always_comb
    begin
        d_next[0] = DIFF_W'(bx) - DIFF_W'(ax);
        d_next[1] = DIFF_W'(by) - DIFF_W'(ay);
        d_next[2] = DIFF_W'(bz) - DIFF_W'(az);
        for (int i = 0; i < 3; i++)
        begin
            side1_next.neg[i] = d_reg[i][DIFF_W-1];
            side1_next.mag[i] = d_reg[i][DIFF_W-1] ? DIFF_W'(-d_reg[i]) : DIFF_W'(d_reg[i]);
        end
        side1_next.zero = (d_reg[0] == '0) && (d_reg[1] == '0) && (d_reg[2] == '0);
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = SUM_W'(side1_reg.mag[i]) * SUM_W'(side1_reg.mag[i]);
        end
        sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i]  <= d_next[i];
                sq_reg[i] <= sq_next[i];
            end
            side1_reg <= side1_next;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
            sum_reg   <= sum_next;
        end
    end

    assign vld  = vld_reg[3];
    assign side = side3_reg;
    assign sum  = sum_reg;

endmodule
`default_nettype wire

// ===== rtl/duv_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// duv_sqrt_cell
// One digit of the integer square root: takes the next two radicand bits
// and settles one root bit.
// ----------------------------------------------------------------------------
module duv_sqrt_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          vld_in,
    input  wire logic [duv_pkg::SUM_W-1:0]     rad_in,
    input  wire logic [duv_pkg::REM_W-1:0]     rem_in,
    input  wire logic [duv_pkg::ROOT_W-1:0]    root_in,
    input  wire duv_pkg::side_t                side_in,
    output logic                               vld_out,
    output logic [duv_pkg::SUM_W-1:0]          rad_out,
    output logic [duv_pkg::REM_W-1:0]          rem_out,
    output logic [duv_pkg::ROOT_W-1:0]         root_out,
    output duv_pkg::side_t                     side_out
);
    import duv_pkg::*;

    localparam int WIDE_W = REM_W + 2;

    logic                vld_reg;
    logic [SUM_W-1:0]    rad_reg, rad_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    side_t               side_reg;
    logic [WIDE_W-1:0]   rem_wide;
    logic [WIDE_W-1:0]   trial;
    logic [WIDE_W-1:0]   diff;
    logic                ge;

    always_comb
    begin
        rem_wide  = {rem_in, rad_in[SUM_W-1 -: 2]};
        trial     = WIDE_W'({root_in, 2'b01});
        diff      = rem_wide - trial;
        ge        = (rem_wide >= trial);
        rem_next  = ge ? diff[REM_W-1:0] : rem_wide[REM_W-1:0];
        root_next = {root_in[ROOT_W-2:0], ge};
        rad_next  = {rad_in[SUM_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule
`default_nettype wire

// ===== rtl/duv_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// duv_div_cell
// One restoring division step for all three components against twice the
// shared distance.
// ----------------------------------------------------------------------------
module duv_div_cell #(
    parameter int QW = duv_pkg::UNIT_FRAC_BITS_DEF + 2
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 vld_in,
    input  wire duv_pkg::tag_t                        tag_in,
    input  wire logic [2:0][duv_pkg::DREM_W-1:0]      r_in,
    input  wire logic [2:0][QW-1:0]                   q_in,
    output logic                                      vld_out,
    output duv_pkg::tag_t                             tag_out,
    output logic [2:0][duv_pkg::DREM_W-1:0]           r_out,
    output logic [2:0][QW-1:0]                        q_out
);
    import duv_pkg::*;

    localparam int WIDE_W = DREM_W + 1;

    logic                       vld_reg;
    tag_t                       tag_reg;
    logic [2:0][DREM_W-1:0]     r_reg, r_next;
    logic [2:0][QW-1:0]         q_reg, q_next;
    logic [WIDE_W-1:0]          divisor;
    logic [WIDE_W-1:0]          r_wide [3];
    logic [WIDE_W-1:0]          diff [3];
    logic [2:0]                 ge;

    always_comb
    begin
        // magnitude never exceeds the distance, so the remainder stays below 2 * dist
        divisor = WIDE_W'({tag_in.root, 1'b0});
        for (int i = 0; i < 3; i++)
        begin
            r_wide[i] = {r_in[i], 1'b0};
            diff[i]   = r_wide[i] - divisor;
            ge[i]     = (r_wide[i] >= divisor);
            r_next[i] = ge[i] ? diff[i][DREM_W-1:0] : r_wide[i][DREM_W-1:0];
            q_next[i] = {q_in[i][QW-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg <= tag_in;
            r_reg   <= r_next;
            q_reg   <= q_next;
        end
    end

    assign vld_out = vld_reg;
    assign tag_out = tag_reg;
    assign r_out   = r_reg;
    assign q_out   = q_reg;

endmodule
`default_nettype wire

// ===== rtl/displacement_unit_vector_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// displacement_unit_vector_unit
// Distance and unit vector between two 3-D fixed-point points.
// ----------------------------------------------------------------------------
// Takes one point pair per cycle while the output is not held off and
// returns one result per request, in order. Four front stages form b - a,
// magnitudes, squares and their sum; a row of 32 cells each settles one bit
// of the floored square root; a row of UNIT_FRAC_BITS + 2 cells each
// settles one quotient bit of all three components; a final register
// applies sign and the coincident case. When the output is held off, the
// whole pipeline freezes and in_ready drops in the same cycle. Coincident
// points give distance 0, a zero unit vector and coincident set.
// ----------------------------------------------------------------------------
module displacement_unit_vector_unit #(
    parameter int UNIT_FRAC_BITS = duv_pkg::UNIT_FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [duv_pkg::COORD_W-1:0]  ax,
    input  wire logic signed [duv_pkg::COORD_W-1:0]  ay,
    input  wire logic signed [duv_pkg::COORD_W-1:0]  az,
    input  wire logic signed [duv_pkg::COORD_W-1:0]  bx,
    input  wire logic signed [duv_pkg::COORD_W-1:0]  by,
    input  wire logic signed [duv_pkg::COORD_W-1:0]  bz,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [duv_pkg::OUT_W-1:0]                distance,
    output logic signed [duv_pkg::OUT_W-1:0]         unit_x,
    output logic signed [duv_pkg::OUT_W-1:0]         unit_y,
    output logic signed [duv_pkg::OUT_W-1:0]         unit_z,
    output logic                                     coincident
);
    import duv_pkg::*;

    localparam int NSQ  = ROOT_W;
    localparam int QW   = UNIT_FRAC_BITS + 2;
    localparam int NDIV = QW;
    localparam logic signed [OUT_W:0] UNIT_ONE = (OUT_W+1)'(1) <<< UNIT_FRAC_BITS;

    logic en;

    logic                      sq_vld  [0:NSQ];
    logic [SUM_W-1:0]          sq_rad  [0:NSQ];
    logic [REM_W-1:0]          sq_rem  [0:NSQ];
    logic [ROOT_W-1:0]         sq_root [0:NSQ];
    side_t                     sq_side [0:NSQ];

    logic                      dv_vld [0:NDIV];
    tag_t                      dv_tag [0:NDIV];
    logic [2:0][DREM_W-1:0]    dv_r   [0:NDIV];
    logic [2:0][QW-1:0]        dv_q   [0:NDIV];

    logic                      out_vld_reg;
    logic [OUT_W-1:0]          dist_reg, dist_next;
    logic [2:0][OUT_W-1:0]     unit_reg, unit_next;
    logic                      coin_reg;
    logic [OUT_W-1:0]          mag_q;

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    duv_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (in_valid),
        .ax     (ax),
        .ay     (ay),
        .az     (az),
        .bx     (bx),
        .by     (by),
        .bz     (bz),
        .vld    (sq_vld[0]),
        .side   (sq_side[0]),
        .sum    (sq_rad[0])
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        duv_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (sq_vld[k]),
            .rad_in   (sq_rad[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .side_in  (sq_side[k]),
            .vld_out  (sq_vld[k+1]),
            .rad_out  (sq_rad[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1]),
            .side_out (sq_side[k+1])
        );
    end

    // quotient of (mag << QW) / (2 * dist), then dropped by one bit at the end
    assign dv_vld[0]      = sq_vld[NSQ];
    assign dv_tag[0].root = sq_root[NSQ];
    assign dv_tag[0].neg  = sq_side[NSQ].neg;
    assign dv_tag[0].zero = sq_side[NSQ].zero;
    assign dv_r[0] = {DREM_W'(sq_side[NSQ].mag[2]), DREM_W'(sq_side[NSQ].mag[1]),
                      DREM_W'(sq_side[NSQ].mag[0])};
    assign dv_q[0] = '0;

    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        duv_div_cell #(
            .QW (QW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (dv_vld[k]),
            .tag_in  (dv_tag[k]),
            .r_in    (dv_r[k]),
            .q_in    (dv_q[k]),
            .vld_out (dv_vld[k+1]),
            .tag_out (dv_tag[k+1]),
            .r_out   (dv_r[k+1]),
            .q_out   (dv_q[k+1])
        );
    end

    always_comb
    begin
        dist_next = dv_tag[NDIV].root;
        mag_q     = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag_q = OUT_W'(dv_q[NDIV][i] >> 1);
            if (dv_tag[NDIV].zero)
            begin
                unit_next[i] = '0;
            end
            else if (dv_tag[NDIV].neg[i])
            begin
                unit_next[i] = OUT_W'(-mag_q);
            end
            else
            begin
                unit_next[i] = mag_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= dv_vld[NDIV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= dist_next;
            unit_reg <= unit_next;
            coin_reg <= dv_tag[NDIV].zero;
        end
    end

    assign out_valid  = out_vld_reg;
    assign distance   = dist_reg;
    assign unit_x     = unit_reg[0];
    assign unit_y     = unit_reg[1];
    assign unit_z     = unit_reg[2];
    assign coincident = coin_reg;

    a_zero_dist : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((distance == '0) == coincident))
        else $error("distance and coincident flag disagree");

    a_coin_unit : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && coincident) |-> (unit_x == '0 && unit_y == '0 && unit_z == '0))
        else $error("nonzero unit vector for coincident points");

    a_unit_x_rng : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((OUT_W+1)'(unit_x) <= UNIT_ONE && (OUT_W+1)'(unit_x) >= -UNIT_ONE))
        else $error("unit_x outside unit range");

    a_stall_freeze : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(distance) && $stable(unit_y))
        else $error("result changed while stalled");

endmodule
`default_nettype wire
